// ===== src/sfmr_pkg.sv =====
// ============================================================================
// sfmr_pkg: shared types and constants of the switch frame matcher/responder
// Frame status codes, reply kinds, register indexes, the Modbus CRC16 byte
// update and the fixed constants of the request and reply frames.
// ============================================================================
`default_nettype none

package sfmr_pkg;

  // Request frame length in bytes
  localparam int unsigned REQUEST_BYTES = 8;

  // Highest valid slave address
  localparam logic [7:0] MAX_ADDRESS = 8'd247;

  // Exception reply: function code flag and exception code
  localparam logic [7:0] EXC_FLAG = 8'h80;
  localparam logic [7:0] EXC_CODE = 8'h03;

  // CRC16 (Modbus): reflected polynomial and start value
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Frame status reported with every result
  typedef enum logic [1:0] {
    ST_NOT_MATCHED = 2'd0,
    ST_HANDLED     = 2'd1,
    ST_ACCEPTED    = 2'd2
  } frame_status_e;

  // Outcome of a frame, selects the reply sequence
  typedef enum logic [1:0] {
    KIND_NO_MATCH = 2'd0,
    KIND_BAD_CRC  = 2'd1,
    KIND_EXCEPT   = 2'd2,
    KIND_ACK      = 2'd3
  } reply_kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_OWN_ADDRESS   = 3'd0,
    REG_FUNCTION_CODE = 3'd1,
    REG_MAGIC_FIRST   = 3'd2,
    REG_MAGIC_SECOND  = 3'd3,
    REG_MAGIC_THIRD   = 3'd4,
    REG_ACK_STATUS    = 3'd5,
    REG_SUPPORTED     = 3'd6
  } cfg_reg_e;

  // One byte through the CRC16, bit by bit (eight narrow steps)
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/switch_frame_matcher_responder_top.sv =====
// ============================================================================
// switch_frame_matcher_responder_top: switch request matcher and responder
// Checks received request frames (address, function code, magic bytes, length,
// CRC16) and emits the acknowledgement or exception reply byte by byte.
// ============================================================================
`default_nettype none

// Received bytes are taken one per cycle and registered in the frame checker,
// which holds the count, header match flag, running CRC16 and the target and
// CRC low bytes. The byte that carries frame_end launches the reply sequencer,
// which produces one result per cycle into an output register unless
// out_ready_i holds it: one result for an unmatched frame or a bad CRC, five
// for an exception reply and six for an acknowledgement. The reply CRC is
// built as the reply bytes go out. Bytes of the next frame are taken while a
// reply is still going out; only the next frame_end byte waits until the
// sequencer has issued the last result of the reply before it. Registers
// are to be written via the configuration port only while idle (not enforced).
module switch_frame_matcher_responder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  // received bytes
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       frame_end_i,
  // results
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      tx_byte_o,
  output logic            byte_valid_o,
  output logic [1:0]      frame_status_o,
  output logic [7:0]      target_out_o,
  output logic            reply_last_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] own_address_q;
  logic [6:0] function_code_q;
  logic [7:0] magic_first_q;
  logic [7:0] magic_second_q;
  logic [7:0] magic_third_q;
  logic [7:0] ack_status_q;
  logic [7:0] supported_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q   <= 8'd1;
      function_code_q <= 7'd0;
      magic_first_q   <= 8'd76;
      magic_second_q  <= 8'd84;
      magic_third_q   <= 8'd68;
      ack_status_q    <= 8'd0;
      supported_q     <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfmr_pkg::REG_OWN_ADDRESS:   own_address_q   <= cfg_wdata_i;
        sfmr_pkg::REG_FUNCTION_CODE: function_code_q <= cfg_wdata_i[6:0];
        sfmr_pkg::REG_MAGIC_FIRST:   magic_first_q   <= cfg_wdata_i;
        sfmr_pkg::REG_MAGIC_SECOND:  magic_second_q  <= cfg_wdata_i;
        sfmr_pkg::REG_MAGIC_THIRD:   magic_third_q   <= cfg_wdata_i;
        sfmr_pkg::REG_ACK_STATUS:    ack_status_q    <= cfg_wdata_i;
        sfmr_pkg::REG_SUPPORTED:     supported_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame checker state
  // --------------------------------------------------------------------------
  logic [3:0]  byte_count_q, byte_count_d;
  logic        header_ok_q, header_ok_d;
  logic [15:0] running_crc_q, running_crc_d;
  logic [7:0]  target_byte_q, target_byte_d;
  logic [7:0]  crc_low_q, crc_low_d;

  // Reply sequencer state
  logic                  rsp_active_q, rsp_active_d;
  logic [2:0]            rsp_idx_q, rsp_idx_d;
  sfmr_pkg::reply_kind_e rsp_kind_q, rsp_kind_d;
  logic [7:0]            rsp_target_q, rsp_target_d;
  logic [15:0]           rsp_crc_q, rsp_crc_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] tx_byte_q, tx_byte_d;
  logic       byte_valid_q, byte_valid_d;
  logic [1:0] status_q, status_d;
  logic [7:0] target_out_q, target_out_d;
  logic       last_q, last_d;

  logic in_fire;
  logic end_fire;
  logic frame_match;
  logic crc_ok;
  logic target_supported;
  logic rsp_load;

  // Only a frame-end byte waits for the sequencer
  assign in_ready_o = !rsp_active_q || !frame_end_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign end_fire   = in_fire && frame_end_i;

  // Frame verdict at the last byte
  assign frame_match = header_ok_q &&
                       (byte_count_q == 4'(sfmr_pkg::REQUEST_BYTES - 1)) &&
                       (own_address_q != 8'd0) &&
                       (own_address_q <= sfmr_pkg::MAX_ADDRESS);
  assign crc_ok = ({rx_byte_i, crc_low_q} == running_crc_q);
  assign target_supported = (target_byte_q[7:3] == 5'd0) && supported_q[target_byte_q[2:0]];

  // --------------------------------------------------------------------------
  // Frame checker: header compare, CRC, captured bytes, saturating count
  // --------------------------------------------------------------------------
  always_comb begin
    byte_count_d  = byte_count_q;
    header_ok_d   = header_ok_q;
    running_crc_d = running_crc_q;
    target_byte_d = target_byte_q;
    crc_low_d     = crc_low_q;
    if (in_fire) begin
      unique case (byte_count_q)
        4'd0: if (rx_byte_i != own_address_q) header_ok_d = 1'b0;
        4'd1: if (rx_byte_i != {1'b0, function_code_q}) header_ok_d = 1'b0;
        4'd2: if (rx_byte_i != magic_first_q) header_ok_d = 1'b0;
        4'd3: if (rx_byte_i != magic_second_q) header_ok_d = 1'b0;
        4'd4: if (rx_byte_i != magic_third_q) header_ok_d = 1'b0;
        4'd5: target_byte_d = rx_byte_i;
        4'd6: crc_low_d = rx_byte_i;
        default: ;
      endcase
      if (byte_count_q < 4'd6) begin
        running_crc_d = sfmr_pkg::crc16_feed(running_crc_q, rx_byte_i);
      end
      if (byte_count_q != 4'hF) begin
        byte_count_d = byte_count_q + 4'd1;
      end
      // frame done: start over
      if (frame_end_i) begin
        byte_count_d  = 4'd0;
        header_ok_d   = 1'b1;
        running_crc_d = sfmr_pkg::CRC_INIT;
        target_byte_d = 8'd0;
        crc_low_d     = 8'd0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Reply sequencer: one result per cycle into a free output register
  // --------------------------------------------------------------------------
  assign rsp_load = rsp_active_q && (!out_valid_q || out_ready_i);

  always_comb begin
    logic       is_data;
    logic       is_last;
    logic [7:0] data_byte;

    rsp_active_d = rsp_active_q;
    rsp_idx_d    = rsp_idx_q;
    rsp_kind_d   = rsp_kind_q;
    rsp_target_d = rsp_target_q;
    rsp_crc_d    = rsp_crc_q;

    out_valid_d  = out_valid_q && !out_ready_i;
    tx_byte_d    = tx_byte_q;
    byte_valid_d = byte_valid_q;
    status_d     = status_q;
    target_out_d = target_out_q;
    last_d       = last_q;

    is_data   = 1'b0;
    is_last   = 1'b0;
    data_byte = 8'd0;

    // pick the byte at the current reply position
    unique case (rsp_kind_q)
      sfmr_pkg::KIND_NO_MATCH, sfmr_pkg::KIND_BAD_CRC: begin
        is_last = 1'b1;
      end
      sfmr_pkg::KIND_EXCEPT: begin
        unique case (rsp_idx_q)
          3'd0: begin
            data_byte = own_address_q;
            is_data   = 1'b1;
          end
          3'd1: begin
            data_byte = {1'b0, function_code_q} | sfmr_pkg::EXC_FLAG;
            is_data   = 1'b1;
          end
          3'd2: begin
            data_byte = sfmr_pkg::EXC_CODE;
            is_data   = 1'b1;
          end
          3'd3: data_byte = rsp_crc_q[7:0];
          default: begin
            data_byte = rsp_crc_q[15:8];
            is_last   = 1'b1;
          end
        endcase
      end
      sfmr_pkg::KIND_ACK: begin
        unique case (rsp_idx_q)
          3'd0: begin
            data_byte = own_address_q;
            is_data   = 1'b1;
          end
          3'd1: begin
            data_byte = {1'b0, function_code_q};
            is_data   = 1'b1;
          end
          3'd2: begin
            data_byte = ack_status_q;
            is_data   = 1'b1;
          end
          3'd3: begin
            data_byte = rsp_target_q;
            is_data   = 1'b1;
          end
          3'd4: data_byte = rsp_crc_q[7:0];
          default: begin
            data_byte = rsp_crc_q[15:8];
            is_last   = 1'b1;
          end
        endcase
      end
      default: ;
    endcase

    if (rsp_load) begin
      out_valid_d  = 1'b1;
      tx_byte_d    = data_byte;
      last_d       = is_last;
      rsp_idx_d    = rsp_idx_q + 3'd1;
      unique case (rsp_kind_q)
        sfmr_pkg::KIND_NO_MATCH: begin
          byte_valid_d = 1'b0;
          status_d     = sfmr_pkg::ST_NOT_MATCHED;
          target_out_d = 8'd0;
        end
        sfmr_pkg::KIND_BAD_CRC, sfmr_pkg::KIND_EXCEPT: begin
          byte_valid_d = (rsp_kind_q == sfmr_pkg::KIND_EXCEPT);
          status_d     = sfmr_pkg::ST_HANDLED;
          target_out_d = 8'd0;
        end
        default: begin
          byte_valid_d = 1'b1;
          status_d     = sfmr_pkg::ST_ACCEPTED;
          target_out_d = rsp_target_q;
        end
      endcase
      if (is_data) begin
        rsp_crc_d = sfmr_pkg::crc16_feed(rsp_crc_q, data_byte);
      end
      if (is_last) begin
        rsp_active_d = 1'b0;
      end
    end

    // launch a reply on the frame-end byte (sequencer is idle then)
    if (end_fire) begin
      rsp_active_d = 1'b1;
      rsp_idx_d    = 3'd0;
      rsp_crc_d    = sfmr_pkg::CRC_INIT;
      rsp_target_d = target_byte_q;
      priority if (!frame_match) begin
        rsp_kind_d = sfmr_pkg::KIND_NO_MATCH;
      end else if (!crc_ok) begin
        rsp_kind_d = sfmr_pkg::KIND_BAD_CRC;
      end else if (target_supported) begin
        rsp_kind_d = sfmr_pkg::KIND_ACK;
      end else begin
        rsp_kind_d = sfmr_pkg::KIND_EXCEPT;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= 4'd0;
      header_ok_q   <= 1'b1;
      running_crc_q <= sfmr_pkg::CRC_INIT;
      target_byte_q <= 8'd0;
      crc_low_q     <= 8'd0;
      rsp_active_q  <= 1'b0;
      rsp_idx_q     <= 3'd0;
      rsp_kind_q    <= sfmr_pkg::KIND_NO_MATCH;
      out_valid_q   <= 1'b0;
    end else begin
      byte_count_q  <= byte_count_d;
      header_ok_q   <= header_ok_d;
      running_crc_q <= running_crc_d;
      target_byte_q <= target_byte_d;
      crc_low_q     <= crc_low_d;
      rsp_active_q  <= rsp_active_d;
      rsp_idx_q     <= rsp_idx_d;
      rsp_kind_q    <= rsp_kind_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rsp_target_q <= rsp_target_d;
    rsp_crc_q    <= rsp_crc_d;
    tx_byte_q    <= tx_byte_d;
    byte_valid_q <= byte_valid_d;
    status_q     <= status_d;
    target_out_q <= target_out_d;
    last_q       <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign tx_byte_o      = tx_byte_q;
  assign byte_valid_o   = byte_valid_q;
  assign frame_status_o = status_q;
  assign target_out_o   = target_out_q;
  assign reply_last_o   = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a result without a reply byte is always the only result of its frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> reply_last_o)
    else $error("result without reply byte is not the last one");

  // target is only reported for accepted frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o != sfmr_pkg::ST_ACCEPTED) |-> target_out_o == 8'd0)
    else $error("target reported for a frame that was not accepted");

  // a frame-end request always starts the reply sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && frame_end_i |=> rsp_active_q && rsp_idx_q == 3'd0)
    else $error("frame end did not launch a reply");

  // the checker is back at the start of a frame after a frame-end request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && frame_end_i |=> byte_count_q == 4'd0 && header_ok_q)
    else $error("frame state not cleared after frame end");

endmodule

`default_nettype wire
